>>> hdl/ocu_pkg.sv
package ocu_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX       = 24;

  localparam logic [2:0] REG_SENS        = 3'd0;
  localparam logic [2:0] REG_YAW_SPEED   = 3'd1;
  localparam logic [2:0] REG_PITCH_SPEED = 3'd2;
  localparam logic [2:0] REG_PITCH_MIN   = 3'd3;
  localparam logic [2:0] REG_PITCH_MAX   = 3'd4;
  localparam logic [2:0] REG_DISTANCE    = 3'd5;
  localparam logic [2:0] REG_HEIGHT_OFS  = 3'd6;
  localparam logic [2:0] REG_LOOK_OFS    = 3'd7;

  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [16:0] PI_Q13      = 17'sd25736;
  localparam logic signed [16:0] TWO_PI_Q13  = 17'sd51472;

  typedef struct packed {
    logic start_sqrt;
    logic start_div;
  } sqdiv_ctl_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:    v = 31'd843314857;
      5'd1:    v = 31'd497837829;
      5'd2:    v = 31'd263043837;
      5'd3:    v = 31'd133525159;
      5'd4:    v = 31'd67021687;
      5'd5:    v = 31'd33543516;
      5'd6:    v = 31'd16775851;
      5'd7:    v = 31'd8388437;
      5'd8:    v = 31'd4194283;
      5'd9:    v = 31'd2097149;
      5'd10:   v = 31'd1048576;
      5'd11:   v = 31'd524288;
      5'd12:   v = 31'd262144;
      5'd13:   v = 31'd131072;
      5'd14:   v = 31'd65536;
      5'd15:   v = 31'd32768;
      5'd16:   v = 31'd16384;
      5'd17:   v = 31'd8192;
      5'd18:   v = 31'd4096;
      5'd19:   v = 31'd2048;
      5'd20:   v = 31'd1024;
      5'd21:   v = 31'd512;
      5'd22:   v = 31'd256;
      5'd23:   v = 31'd128;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) r = 32'sh7fffffff;
    else if (v < -35'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
    logic signed [15:0] r;
    if (v > 35'sd32767) r = 16'sh7fff;
    else if (v < -35'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

>>> hdl/ocu_cordic.sv
module ocu_cordic
  import ocu_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [16:0] ang_in,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic               done
);

  localparam int N  = (STEPS > CORDIC_MAX) ? CORDIC_MAX : STEPS;
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  logic               busy;
  logic [IW-1:0]      i;
  logic signed [31:0] x, y;
  logic signed [33:0] z;
  logic               flip;
  logic signed [16:0] angf;
  logic signed [31:0] dx, dy;
  logic signed [33:0] at;

  assign flip = (ang_in > HALF_PI_Q13) || (ang_in < -HALF_PI_Q13);
  assign angf = !flip ? ang_in : ((ang_in > 17'sd0) ? ang_in - PI_Q13 : ang_in + PI_Q13);
  assign dx   = y >>> i;
  assign dy   = x >>> i;
  assign at   = {3'b000, atan_q30(5'(i))};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= busy && !start && (i == IW'(N - 1));
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
        x    <= flip ? -x_in : x_in;
        y    <= flip ? -y_in : y_in;
        z    <= {angf, 17'b0};
      end else if (busy) begin
        if (!z[33]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        if (i == IW'(N - 1)) begin
          busy <= 1'b0;
        end else begin
          i <= i + 1'b1;
        end
      end
    end
  end

  assign x_out = x;
  assign y_out = y;

endmodule

>>> hdl/ocu_sqdiv.sv
module ocu_sqdiv
  import ocu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sqdiv_ctl_t  ctl,
  input  logic [53:0] rad,
  input  logic [56:0] num,
  input  logic [26:0] den,
  output logic [33:0] res,
  output logic        done
);

  logic        busy;
  logic        is_div;
  logic [5:0]  cnt;
  logic [57:0] acc;
  logic [53:0] rq;
  logic [59:0] sh;
  logic [53:0] trial;
  logic        ge_sq, ge_dv;

  assign trial = rq + sh[53:0];
  assign ge_sq = {4'b0, trial} <= acc;
  assign ge_dv = sh <= {2'b0, acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !ctl.start_sqrt && !ctl.start_div && (cnt == 6'd1);
      if (ctl.start_sqrt) begin
        busy   <= 1'b1;
        is_div <= 1'b0;
        cnt    <= 6'd27;
        acc    <= {4'b0, rad};
        rq     <= '0;
        sh     <= 60'd1 << 52;
      end else if (ctl.start_div) begin
        busy   <= 1'b1;
        is_div <= 1'b1;
        cnt    <= 6'd34;
        acc    <= {1'b0, num} + {32'b0, den[26:1]};
        rq     <= '0;
        sh     <= {den, 33'b0};
      end else if (busy) begin
        if (!is_div) begin
          if (ge_sq) begin
            acc <= acc - {4'b0, trial};
            rq  <= (rq >> 1) + sh[53:0];
          end else begin
            rq <= rq >> 1;
          end
          sh <= sh >> 2;
        end else begin
          if (ge_dv) acc <= acc - sh[57:0];
          rq <= {rq[52:0], ge_dv};
          sh <= sh >> 1;
        end
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign res = rq[33:0];

endmodule

>>> hdl/orbit_camera_update_top.sv
// channel | direction | handshake               | words
// in      | in        | in_valid / in_ready     | active, stick_x/y, frame_time, target_x/y/z
// out     | out       | out_valid / out_ready   | cam_x/y/z, look_x/y/z
// cfg     | in        | cfg_we                  | cfg_index, cfg_data
// One word at a time; an active word runs through the shared CORDIC unit (two passes),
// the bit-serial square root (two passes) and the bit-serial divider (four passes); the
// heading's two divisions are skipped when the turned heading has zero length.
// An inactive word is taken and gives nothing.
// A finished result sits in the output register; the next word may be taken meanwhile.
// A result not yet taken holds the sequencer in its last step.
// rst is synchronous and restores registers, pitch and heading.
module orbit_camera_update_top
  import ocu_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               active,
  input  logic signed [15:0] stick_x,
  input  logic signed [15:0] stick_y,
  input  logic [15:0]        frame_time,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] cam_x,
  output logic signed [31:0] cam_y,
  output logic signed [31:0] cam_z,
  output logic signed [31:0] look_x,
  output logic signed [31:0] look_y,
  output logic signed [31:0] look_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PM1  = 5'd1;
  localparam logic [4:0] S_PM2  = 5'd2;
  localparam logic [4:0] S_PM3  = 5'd3;
  localparam logic [4:0] S_PUP  = 5'd4;
  localparam logic [4:0] S_YM1  = 5'd5;
  localparam logic [4:0] S_YM2  = 5'd6;
  localparam logic [4:0] S_YM3  = 5'd7;
  localparam logic [4:0] S_YST  = 5'd8;
  localparam logic [4:0] S_YMOD = 5'd9;
  localparam logic [4:0] S_YRS  = 5'd10;
  localparam logic [4:0] S_ROT  = 5'd11;
  localparam logic [4:0] S_SQ1  = 5'd12;
  localparam logic [4:0] S_SQ2  = 5'd13;
  localparam logic [4:0] S_SQ3  = 5'd14;
  localparam logic [4:0] S_SQRT = 5'd15;
  localparam logic [4:0] S_D1S  = 5'd16;
  localparam logic [4:0] S_D1W  = 5'd17;
  localparam logic [4:0] S_D2S  = 5'd18;
  localparam logic [4:0] S_D2W  = 5'd19;
  localparam logic [4:0] S_PRS  = 5'd20;
  localparam logic [4:0] S_DM1  = 5'd21;
  localparam logic [4:0] S_DM2  = 5'd22;
  localparam logic [4:0] S_DM3  = 5'd23;
  localparam logic [4:0] S_DM4  = 5'd24;
  localparam logic [4:0] S_DM5  = 5'd25;
  localparam logic [4:0] S_OUT  = 5'd26;

  localparam logic signed [22:0] YAW_BIAS = 23'sd1080912; // 21 turns
  localparam logic signed [31:0] VEC_ONE  = 32'sd16777216;

  // configuration
  logic signed [15:0] sens;
  logic [15:0]        yaw_speed, pitch_speed;
  logic signed [14:0] pitch_min, pitch_max;
  logic [30:0]        distance;
  logic signed [31:0] height_ofs, look_ofs;

  // state
  logic signed [15:0] pitch, hx, hz;

  logic [4:0]         state;
  logic               phase;
  logic signed [15:0] sx, sy;
  logic [15:0]        ft;
  logic signed [31:0] tx, ty, tz;
  logic [53:0]        t1;
  logic signed [22:0] ymod;
  logic [2:0]         k;
  logic signed [31:0] cx, cy;
  logic [26:0]        len;
  logic               dneg;
  logic signed [34:0] q1;
  logic signed [31:0] cosv, sinv;
  logic signed [32:0] hd, vd;
  logic signed [31:0] res_x, res_z;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;

  logic [63:0]        rnd42, rnd30, rnd15;
  logic signed [21:0] step;
  logic signed [22:0] pd, pc1, pc2;
  logic [22:0]        ysub;
  logic [15:0]        yr;
  logic signed [16:0] yaw;

  logic               cor_start, cor_done;
  logic signed [31:0] cor_x, cor_y, cor_xo, cor_yo;
  logic signed [16:0] cor_ang;

  sqdiv_ctl_t         sd_ctl;
  logic [53:0]        sd_rad;
  logic [56:0]        sd_num;
  logic [33:0]        sd_res;
  logic               sd_done;
  logic signed [31:0] dsrc, dmag;
  logic signed [34:0] qs;
  logic signed [33:0] hterm;

  assign in_ready = (state == S_IDLE);

  // shared multiplier
  always_comb begin
    case (state)
      S_PM1, S_YM1: begin
        mul_a = 34'(sy);
        mul_b = 34'(sens);
        if (state == S_YM1) mul_a = 34'(sx);
      end
      S_PM2: begin
        mul_a = {18'b0, pitch_speed};
        mul_b = {18'b0, ft};
      end
      S_YM2: begin
        mul_a = {18'b0, yaw_speed};
        mul_b = {18'b0, ft};
      end
      S_PM3, S_YM3: begin
        mul_a = 34'(signed'(t1[31:0]));
        mul_b = {2'b0, mul_p[31:0]};
      end
      S_SQ1: begin
        mul_a = 34'(cx);
        mul_b = 34'(cx);
      end
      S_SQ2: begin
        mul_a = 34'(cy);
        mul_b = 34'(cy);
      end
      S_DM1: begin
        mul_a = {3'b0, distance};
        mul_b = 34'(cosv);
      end
      S_DM2: begin
        mul_a = {3'b0, distance};
        mul_b = 34'(sinv);
      end
      S_DM3: begin
        mul_a = 34'(hx);
        mul_b = 34'(hd);
      end
      S_DM4: begin
        mul_a = 34'(hz);
        mul_b = 34'(hd);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) mul_p <= mul_a * mul_b;

  assign rnd42 = mul_p[63:0] + (64'd1 << 41);
  assign rnd30 = mul_p[63:0] + (64'd1 << 29);
  assign rnd15 = mul_p[63:0] + (64'd1 << 14);
  assign step  = rnd42[63:42];
  assign hterm = rnd15[48:15];

  assign pd  = 23'(pitch) - 23'(step);
  assign pc1 = (pd < 23'(pitch_min)) ? 23'(pitch_min) : pd;
  assign pc2 = (pc1 > 23'(pitch_max)) ? 23'(pitch_max) : pc1;

  assign ysub = 23'(TWO_PI_Q13) << k;
  assign yr   = ymod[15:0];
  assign yaw  = ({1'b0, yr} > PI_Q13) ? {1'b0, yr} - TWO_PI_Q13 : {1'b0, yr};

  // CORDIC rotator
  assign cor_start = (state == S_YRS) || (state == S_PRS);
  assign cor_x     = (state == S_YRS) ? {{7{hz[15]}}, hz, 9'b0} : VEC_ONE;
  assign cor_y     = (state == S_YRS) ? {{7{hx[15]}}, hx, 9'b0} : 32'sd0;
  assign cor_ang   = (state == S_YRS) ? yaw : 17'(pitch);

  ocu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cor_start),
    .x_in   (cor_x),
    .y_in   (cor_y),
    .ang_in (cor_ang),
    .x_out  (cor_xo),
    .y_out  (cor_yo),
    .done   (cor_done)
  );

  // root and divider
  assign dsrc = (state == S_D1S) ? cy : cx;
  assign dmag = dsrc[31] ? -dsrc : dsrc;
  assign sd_num = phase ? {dmag[26:0], 30'b0} : {15'b0, dmag[26:0], 15'b0};
  assign sd_rad = t1 + mul_p[53:0];
  assign sd_ctl.start_sqrt = (state == S_SQ3);
  assign sd_ctl.start_div  = (state == S_D1S) || (state == S_D2S);
  assign qs = dneg ? -{1'b0, sd_res} : {1'b0, sd_res};

  ocu_sqdiv u_sqdiv (
    .clk  (clk),
    .rst  (rst),
    .ctl  (sd_ctl),
    .rad  (sd_rad),
    .num  (sd_num),
    .den  (len),
    .res  (sd_res),
    .done (sd_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sens        <= 16'sd4096;
      yaw_speed   <= 16'd8192;
      pitch_speed <= 16'd8192;
      pitch_min   <= -15'sd4096;
      pitch_max   <= 15'sd8192;
      distance    <= 31'd327680;
      height_ofs  <= '0;
      look_ofs    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENS:        sens        <= cfg_data[15:0];
        REG_YAW_SPEED:   yaw_speed   <= cfg_data[15:0];
        REG_PITCH_SPEED: pitch_speed <= cfg_data[15:0];
        REG_PITCH_MIN:   pitch_min   <= cfg_data[14:0];
        REG_PITCH_MAX:   pitch_max   <= cfg_data[14:0];
        REG_DISTANCE:    distance    <= cfg_data[30:0];
        REG_HEIGHT_OFS:  height_ofs  <= cfg_data;
        REG_LOOK_OFS:    look_ofs    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 1'b0;
      k         <= '0;
      pitch     <= '0;
      hx        <= '0;
      hz        <= -16'sd32768;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sx <= stick_x;
            sy <= stick_y;
            ft <= frame_time;
            tx <= target_x;
            ty <= target_y;
            tz <= target_z;
            if (active) state <= S_PM1;
          end
        end
        S_PM1: state <= S_PM2;
        S_PM2: begin
          t1    <= mul_p[53:0];
          state <= S_PM3;
        end
        S_PM3: state <= S_PUP;
        S_PUP: begin
          pitch <= pc2[15:0];
          state <= S_YM1;
        end
        S_YM1: state <= S_YM2;
        S_YM2: begin
          t1    <= mul_p[53:0];
          state <= S_YM3;
        end
        S_YM3: state <= S_YST;
        S_YST: begin
          ymod  <= 23'(step) + YAW_BIAS;
          k     <= 3'd5;
          state <= S_YMOD;
        end
        S_YMOD: begin
          if (ymod >= signed'(ysub)) ymod <= ymod - signed'(ysub);
          if (k == 3'd0) state <= S_YRS;
          else k <= k - 1'b1;
        end
        S_YRS: begin
          phase <= 1'b0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (cor_done) begin
            cx    <= cor_xo;
            cy    <= cor_yo;
            state <= S_SQ1;
          end
        end
        S_SQ1: state <= S_SQ2;
        S_SQ2: begin
          t1    <= mul_p[53:0];
          state <= S_SQ3;
        end
        S_SQ3: state <= S_SQRT;
        S_SQRT: begin
          if (sd_done) begin
            len <= sd_res[26:0];
            // zero-length heading keeps its old value
            if (!phase && sd_res[26:0] == 27'd0) state <= S_PRS;
            else state <= S_D1S;
          end
        end
        S_D1S: begin
          dneg  <= dsrc[31];
          state <= S_D1W;
        end
        S_D1W: begin
          if (sd_done) begin
            q1    <= qs;
            state <= S_D2S;
          end
        end
        S_D2S: begin
          dneg  <= dsrc[31];
          state <= S_D2W;
        end
        S_D2W: begin
          if (sd_done) begin
            if (!phase) begin
              hx    <= sat16(q1);
              hz    <= sat16(qs);
              state <= S_PRS;
            end else begin
              sinv  <= q1[31:0];
              cosv  <= qs[31:0];
              state <= S_DM1;
            end
          end
        end
        S_PRS: begin
          phase <= 1'b1;
          state <= S_ROT;
        end
        S_DM1: state <= S_DM2;
        S_DM2: begin
          hd    <= rnd30[62:30];
          state <= S_DM3;
        end
        S_DM3: begin
          vd    <= rnd30[62:30];
          state <= S_DM4;
        end
        S_DM4: begin
          res_x <= sat32(35'(tx) + 35'(hterm));
          state <= S_DM5;
        end
        S_DM5: begin
          res_z <= sat32(35'(tz) + 35'(hterm));
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            cam_x     <= res_x;
            cam_y     <= sat32(35'(ty) + 35'(vd) + 35'(height_ofs));
            cam_z     <= res_z;
            look_x    <= tx;
            look_y    <= sat32(35'(ty) + 35'(look_ofs));
            look_z    <= tz;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/ocu_checker.sv
module ocu_checker
  import ocu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               active,
  input  logic signed [15:0] stick_x,
  input  logic signed [15:0] stick_y,
  input  logic [15:0]        frame_time,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] cam_x,
  input  logic signed [31:0] cam_y,
  input  logic signed [31:0] cam_z,
  input  logic signed [31:0] look_x,
  input  logic signed [31:0] look_y,
  input  logic signed [31:0] look_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] cx, cy, cz, lx, ly, lz;
  } view_t;

  view_t view_q[$];

  logic signed [15:0] sens;
  logic [15:0]        yaw_spd, pitch_spd;
  logic signed [14:0] p_min, p_max;
  logic [30:0]        orbit_dist;
  logic signed [31:0] h_ofs, l_ofs;
  longint             pitch, hx, hz;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint rnd_div(longint n, longint d);
    longint unsigned mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint sat(longint v, longint lim);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void rotate(inout longint x, inout longint y, input longint ang);
    longint z, dx, dy;
    if (ang > HALF_PI_Q13 || ang < -HALF_PI_Q13) begin
      x = -x;
      y = -y;
      ang = ang + ((ang > 0) ? -PI_Q13 : PI_Q13);
    end
    z = ang * 131072;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_q30(i[4:0]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_q30(i[4:0]);
      end
    end
  endfunction

  function automatic view_t frame_view();
    view_t  v;
    longint p, yaw, a, b, c, s, len, hd, vd;
    p = pitch - rnd_shift(longint'(stick_y) * sens * longint'(pitch_spd) *
                          longint'(frame_time), 42);
    if (p < p_min) p = p_min;
    if (p > p_max) p = p_max;
    pitch = p;
    yaw = rnd_shift(longint'(stick_x) * sens * longint'(yaw_spd) *
                    longint'(frame_time), 42) % TWO_PI_Q13;
    if (yaw < 0) yaw = yaw + TWO_PI_Q13;
    if (yaw > PI_Q13) yaw = yaw - TWO_PI_Q13;
    a = hz * 512;
    b = hx * 512;
    rotate(a, b, yaw);
    len = root(a * a + b * b);
    if (len != 0) begin
      hx = sat(rnd_div(b * 32768, len), 32768);
      hz = sat(rnd_div(a * 32768, len), 32768);
    end
    a = 64'sd16777216;
    b = 0;
    rotate(a, b, p);
    len = root(a * a + b * b);
    c = rnd_div(a * 1073741824, len);
    s = rnd_div(b * 1073741824, len);
    hd = rnd_shift(longint'(orbit_dist) * c, 30);
    vd = rnd_shift(longint'(orbit_dist) * s, 30);
    v.cx = 32'(sat(target_x + rnd_shift(hx * hd, 15), 64'sd2147483648));
    v.cy = 32'(sat(target_y + vd + h_ofs, 64'sd2147483648));
    v.cz = 32'(sat(target_z + rnd_shift(hz * hd, 15), 64'sd2147483648));
    v.lx = target_x;
    v.ly = 32'(sat(target_y + longint'(l_ofs), 64'sd2147483648));
    v.lz = target_z;
    return v;
  endfunction

  always @(posedge clk) begin
    view_t w, e;
    if (rst) begin
      sens <= 16'sd4096;
      yaw_spd <= 16'd8192;
      pitch_spd <= 16'd8192;
      p_min <= -15'sd4096;
      p_max <= 15'sd8192;
      orbit_dist <= 31'd327680;
      h_ofs <= '0;
      l_ofs <= '0;
      pitch = 0;
      hx = 0;
      hz = -32768;
      view_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SENS:        sens <= cfg_data[15:0];
          REG_YAW_SPEED:   yaw_spd <= cfg_data[15:0];
          REG_PITCH_SPEED: pitch_spd <= cfg_data[15:0];
          REG_PITCH_MIN:   p_min <= cfg_data[14:0];
          REG_PITCH_MAX:   p_max <= cfg_data[14:0];
          REG_DISTANCE:    orbit_dist <= cfg_data[30:0];
          REG_HEIGHT_OFS:  h_ofs <= cfg_data;
          REG_LOOK_OFS:    l_ofs <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready && active) view_q.push_back(frame_view());
      if (out_valid && out_ready) begin
        w = '{cam_x, cam_y, cam_z, look_x, look_y, look_z};
        if (view_q.size() == 0) begin
          if (errors < 10) $display("unexpected word %h", w);
          errors <= errors + 1;
        end else begin
          e = view_q.pop_front();
          if (w !== e) begin
            if (errors < 10)
              $display("cam %0d %0d %0d look %0d %0d %0d, want %0d %0d %0d / %0d %0d %0d",
                       w.cx, w.cy, w.cz, w.lx, w.ly, w.lz,
                       e.cx, e.cy, e.cz, e.lx, e.ly, e.lz);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= view_q.size();
  end

endmodule

>>> tb/tb_top.sv
module tb_top;
  import ocu_pkg::*;

  logic               clk, rst;
  logic               in_valid, in_ready, active;
  logic signed [15:0] stick_x, stick_y;
  logic [15:0]        frame_time;
  logic signed [31:0] target_x, target_y, target_z;
  logic               out_valid, out_ready;
  logic signed [31:0] cam_x, cam_y, cam_z, look_x, look_y, look_z;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 errors, pending;
  int                 tx_idle, rx_idle, cycles;
  logic               hold;

  orbit_camera_update_top u_dut (.*);

  ocu_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 4000000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  always @(negedge clk)
    out_ready <= !hold && ($urandom_range(99) >= rx_idle);

  task automatic send(logic a, logic [15:0] sx, logic [15:0] sy, logic [15:0] ft,
                      logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    active <= a;
    stick_x <= sx;
    stick_y <= sy;
    frame_time <= ft;
    target_x <= x;
    target_y <= y;
    target_z <= z;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff - $urandom_range(3);
      1: return 32'h80000000 + $urandom_range(3);
      2: return $urandom;
      default: return $urandom_range(2000000) - 1000000;
    endcase
  endfunction

  function automatic logic [15:0] stick();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic settle();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write(logic [2:0] idx, logic [31:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic configure(int k);
    case (k)
      1: begin
        write(REG_SENS, 32'h8000);
        write(REG_YAW_SPEED, 32'hffff);
        write(REG_PITCH_SPEED, 32'hffff);
        write(REG_PITCH_MIN, -32'sd12868);
        write(REG_PITCH_MAX, 32'd12868);
        write(REG_DISTANCE, 32'h7fffffff);
        write(REG_HEIGHT_OFS, 32'h7fffffff);
        write(REG_LOOK_OFS, 32'h80000000);
      end
      2: begin
        write(REG_SENS, 32'h7fff);
        write(REG_YAW_SPEED, 0);
        write(REG_PITCH_SPEED, 0);
        write(REG_PITCH_MIN, 32'd3000);
        write(REG_PITCH_MAX, -32'sd2000);
        write(REG_DISTANCE, 0);
        write(REG_HEIGHT_OFS, 32'h80000000);
        write(REG_LOOK_OFS, 32'h7fffffff);
      end
      default: begin
        write(REG_SENS, $urandom);
        write(REG_YAW_SPEED, $urandom);
        write(REG_PITCH_SPEED, $urandom);
        write(REG_PITCH_MIN, $urandom_range(25736) - 12868);
        write(REG_PITCH_MAX, $urandom_range(25736) - 12868);
        write(REG_DISTANCE, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 24));
        write(REG_HEIGHT_OFS, $urandom);
        write(REG_LOOK_OFS, $urandom);
      end
    endcase
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    active = 0;
    stick_x = 0;
    stick_y = 0;
    frame_time = 0;
    target_x = 0;
    target_y = 0;
    target_z = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    hold = 0;
    tx_idle = 0;
    rx_idle = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: reset settings
    send(1, 0, 0, 0, 0, 0, 0);
    send(0, 16'h7fff, 16'h7fff, 16'hffff, 1, 2, 3);
    send(1, 16'h7fff, 16'h7fff, 16'hffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send(1, 16'h8000, 16'h8000, 16'hffff, 32'h80000000, 32'h80000000, 32'h80000000);
    send(1, 16'h8000, 16'h7fff, 16'h8000, 32'h00010000, 32'hffff0000, 32'h12345678);
    send(1, 16'h4000, 16'hc000, 16'h0001, 32'hffffffff, 0, 1);
    send(0, 0, 0, 0, 0, 0, 0);
    settle();
    configure(1);
    send(1, 16'h7fff, 16'h7fff, 16'hffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send(1, 16'h8000, 16'h8000, 16'hffff, 32'h80000000, 32'h80000000, 32'h80000000);
    send(1, 16'h1234, 16'h8000, 16'h0400, 0, 0, 0);
    send(1, 16'h0100, 16'h0100, 16'h0100, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
    settle();
    configure(2);
    send(1, 16'h7fff, 16'h8000, 16'hffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send(1, 16'h8000, 16'h7fff, 16'hffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send(0, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);

    for (int ph = 0; ph < 9; ph++) begin
      settle();
      configure(ph == 3 ? 1 : ph == 6 ? 2 : 0);
      tx_idle = ph < 3 ? 20 : ph < 6 ? 57 : 0;
      rx_idle = ph < 3 ? 57 : ph < 6 ? 20 : 0;
      for (int n = 0; n < 180; n++) begin
        if (ph == 1 && n == 20)
          fork
            begin
              hold = 1;
              repeat (3000) @(negedge clk);
              hold = 0;
            end
          join_none
        if (n == 90) begin
          in_valid <= 0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
        send($urandom_range(7) != 0, stick(), stick(),
             16'($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(4096)),
             coord(), coord(), coord());
      end
    end

    settle();
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
